FILE: rtl/core/dual_dial_hash_slot_insert_top_macros.svh
// ----------------------------------------------------------------------------
// Dual dial slot insert - assertion macros
// Concurrent check wrappers shared by the RTL; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef DUAL_DIAL_HASH_SLOT_INSERT_TOP_MACROS_SVH
`define DUAL_DIAL_HASH_SLOT_INSERT_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define DDHS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// next-cycle implication
`define DDHS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`else

`define DDHS_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define DDHS_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/core/ddhs_pkg.sv
// ----------------------------------------------------------------------------
// Dual dial slot insert - package
// Microcode types, step labels, control ROM and register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ddhs_pkg;

   // configuration register indexes
   typedef logic csr_index_type;
   localparam csr_index_type CSR_TABLE_SIZE = 1'b0;
   localparam csr_index_type CSR_DIAL_SIZE  = 1'b1;

   // remainder unit run lengths (dividend bits consumed)
   localparam logic [4:0] MOD_LEN_SHORT = 5'd16;
   localparam logic [4:0] MOD_LEN_KEY   = 5'd31;

   typedef logic [4:0] step_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_CLEAR,
      OP_IDLE,
      OP_MOD_TPOS,
      OP_MOD_DPOS,
      OP_MOD_KEY_T,
      OP_MOD_KEY_D,
      OP_MOD_JUMP,
      OP_LD_TP,
      OP_LD_DP,
      OP_FWD_KEY,
      OP_BACK_KEY,
      OP_JUMP,
      OP_STEP,
      OP_EMIT
   } op_type;

   // jump taken when the selected flag is true
   typedef enum logic [2:0] {
      F_NEVER,
      F_ALWAYS,
      F_CLR_MORE,
      F_NO_REQ,
      F_MOD_BUSY,
      F_FREE,
      F_EXHAUSTED,
      F_OUT_BUSY
   } flag_sel_type;

   typedef struct packed {
      op_type       op;
      flag_sel_type flag;
      step_type     target;
   } ctrl_word_type;

   typedef struct packed {
      logic clr_more;
      logic no_req;
      logic mod_busy;
      logic free;
      logic exhausted;
      logic out_busy;
   } flags_type;

   localparam step_type S_CLEAR   = 5'd0;
   localparam step_type S_IDLE    = 5'd1;
   localparam step_type S_W_TPOS  = 5'd3;
   localparam step_type S_W_DPOS  = 5'd6;
   localparam step_type S_W_KEY_T = 5'd9;
   localparam step_type S_W_KEY_D = 5'd12;
   localparam step_type S_W_JUMP  = 5'd17;
   localparam step_type S_CHECK   = 5'd19;
   localparam step_type S_EMIT    = 5'd22;
   localparam step_type S_DONE    = 5'd23;

   function automatic ctrl_word_type useq_rom(input step_type step);
      ctrl_word_type cw;
      cw = '{op: OP_NOP, flag: F_NEVER, target: S_IDLE};
      unique case (step)
         5'd0:  cw = '{op: OP_CLEAR,    flag: F_CLR_MORE,  target: S_CLEAR};
         5'd1:  cw = '{op: OP_IDLE,     flag: F_NO_REQ,    target: S_IDLE};
         5'd2:  cw = '{op: OP_MOD_TPOS, flag: F_NEVER,     target: S_IDLE};
         5'd3:  cw = '{op: OP_NOP,      flag: F_MOD_BUSY,  target: S_W_TPOS};
         5'd4:  cw = '{op: OP_LD_TP,    flag: F_NEVER,     target: S_IDLE};
         5'd5:  cw = '{op: OP_MOD_DPOS, flag: F_NEVER,     target: S_IDLE};
         5'd6:  cw = '{op: OP_NOP,      flag: F_MOD_BUSY,  target: S_W_DPOS};
         5'd7:  cw = '{op: OP_LD_DP,    flag: F_NEVER,     target: S_IDLE};
         5'd8:  cw = '{op: OP_MOD_KEY_T, flag: F_NEVER,    target: S_IDLE};
         5'd9:  cw = '{op: OP_NOP,      flag: F_MOD_BUSY,  target: S_W_KEY_T};
         5'd10: cw = '{op: OP_FWD_KEY,  flag: F_NEVER,     target: S_IDLE};
         5'd11: cw = '{op: OP_MOD_KEY_D, flag: F_NEVER,    target: S_IDLE};
         5'd12: cw = '{op: OP_NOP,      flag: F_MOD_BUSY,  target: S_W_KEY_D};
         5'd13: cw = '{op: OP_BACK_KEY, flag: F_NEVER,     target: S_IDLE};
         5'd14: cw = '{op: OP_NOP,      flag: F_NEVER,     target: S_IDLE};
         5'd15: cw = '{op: OP_NOP,      flag: F_FREE,      target: S_EMIT};
         5'd16: cw = '{op: OP_MOD_JUMP, flag: F_NEVER,     target: S_IDLE};
         5'd17: cw = '{op: OP_NOP,      flag: F_MOD_BUSY,  target: S_W_JUMP};
         5'd18: cw = '{op: OP_JUMP,     flag: F_NEVER,     target: S_IDLE};
         5'd19: cw = '{op: OP_NOP,      flag: F_EXHAUSTED, target: S_DONE};
         5'd20: cw = '{op: OP_NOP,      flag: F_FREE,      target: S_EMIT};
         5'd21: cw = '{op: OP_STEP,     flag: F_ALWAYS,    target: S_CHECK};
         5'd22: cw = '{op: OP_EMIT,     flag: F_OUT_BUSY,  target: S_EMIT};
         5'd23: cw = '{op: OP_NOP,      flag: F_ALWAYS,    target: S_IDLE};
         default: cw = '{op: OP_NOP,    flag: F_ALWAYS,    target: S_IDLE};
      endcase
      return cw;
   endfunction

endpackage

FILE: rtl/core/ddhs_ram.sv
// ----------------------------------------------------------------------------
// Dual dial slot insert - generic RAM
// Single port, one write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddhs_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 256
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                          wdata,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/core/ddhs_mod.sv
// ----------------------------------------------------------------------------
// Dual dial slot insert - remainder unit
// Restoring remainder, one dividend bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddhs_mod (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [30:0] dividend,   // left aligned
   input  logic [4:0]  nbits,
   input  logic [15:0] divisor,    // never zero
   output logic        busy,
   output logic [15:0] rem
);
   import ddhs_pkg::*;

   logic [30:0] num_ff, num_in;
   logic [15:0] div_ff, div_in;
   logic [15:0] rem_ff, rem_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [16:0] trial;

   assign trial = {rem_ff, num_ff[30]};

   always_comb begin
      num_in = num_ff;
      div_in = div_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (start) begin
         num_in = dividend;
         div_in = divisor;
         rem_in = '0;
         cnt_in = nbits;
      end else if (cnt_ff != '0) begin
         num_in = {num_ff[29:0], 1'b0};
         cnt_in = cnt_ff - 5'd1;
         if (trial >= {1'b0, div_ff}) begin
            rem_in = 16'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      num_ff <= num_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign busy = (cnt_ff != '0);
   assign rem  = rem_ff;

endmodule

FILE: rtl/core/ddhs_useq.sv
// ----------------------------------------------------------------------------
// Dual dial slot insert - microsequencer
// Step counter over the control ROM with flag-selected jumps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddhs_useq (
   input  logic                    clock,
   input  logic                    reset,
   input  ddhs_pkg::flags_type     flags,
   output ddhs_pkg::ctrl_word_type cw
);
   import ddhs_pkg::*;

   step_type      step_ff, step_in;
   ctrl_word_type cw_cur;
   logic          take;

   assign cw_cur = useq_rom(step_ff);

   always_comb begin
      unique case (cw_cur.flag)
         F_NEVER:     take = 1'b0;
         F_ALWAYS:    take = 1'b1;
         F_CLR_MORE:  take = flags.clr_more;
         F_NO_REQ:    take = flags.no_req;
         F_MOD_BUSY:  take = flags.mod_busy;
         F_FREE:      take = flags.free;
         F_EXHAUSTED: take = flags.exhausted;
         F_OUT_BUSY:  take = flags.out_busy;
         default:     take = 1'b0;
      endcase
      step_in = take ? cw_cur.target : step_type'(step_ff + 5'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_CLEAR;
      end else begin
         step_ff <= step_in;
      end
   end

   assign cw = cw_cur;

endmodule

FILE: rtl/core/dual_dial_hash_slot_insert_top.sv
// ----------------------------------------------------------------------------
// Dual dial slot insert - top level
// Flow: from key transfer to slot, four remainder runs (two short ones, two
//   over the full key) dominate when the first probe hits; a collision adds
//   one more remainder run for the jump, then further slots are probed.
// Throughput: one key at a time; the next key is taken once the previous one
//   has finished, while its slot may still wait on the result port.
// Reset: synchronous; afterwards a clearing pass writes every entry of the
//   occupancy RAM to empty before the first key is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dual_dial_hash_slot_insert_top_macros.svh"

module dual_dial_hash_slot_insert_top #(
   parameter int TABLE_DEPTH = 256   // 1 .. 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   // key channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [30:0]            req_key,
   // slot channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [8:0]             rsp_slot,
   // register writes
   input  logic                   csr_we,
   input  ddhs_pkg::csr_index_type csr_index,
   input  logic [15:0]            csr_wdata
);
   import ddhs_pkg::*;

   // index width, effective table size width, tries counter width
   localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int TMW = $clog2(TABLE_DEPTH + 1);
   localparam int CW  = $clog2(TABLE_DEPTH + 2);
   localparam int EW  = (TMW > 9) ? TMW : 9;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [8:0]  table_size_ff;
   logic [15:0] dial_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= 9'd256;
         dial_size_ff  <= 16'd256;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TABLE_SIZE: table_size_ff <= csr_wdata[8:0];
            CSR_DIAL_SIZE:  dial_size_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective moduli: zero acts as one, table clipped to the RAM depth
   logic [EW-1:0]  ts_ext;
   logic [TMW-1:0] tm;
   logic [15:0]    dm;

   assign ts_ext = EW'(table_size_ff);

   always_comb begin
      priority if (ts_ext == '0) begin
         tm = TMW'(1);
      end else if (ts_ext > EW'(TABLE_DEPTH)) begin
         tm = TMW'(TABLE_DEPTH);
      end else begin
         tm = TMW'(ts_ext);
      end
   end

   assign dm = (dial_size_ff == '0) ? 16'd1 : dial_size_ff;

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   ctrl_word_type cw;
   flags_type     flags;

   ddhs_useq u_useq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .cw    (cw)
   );

   // ---------------------------------------------------------------------
   // Datapath registers
   // tp_ff / dp_ff are the persistent dials; they double as the probe
   // position and second dial while an item is in flight.
   // ---------------------------------------------------------------------
   logic [AW-1:0] tp_ff, tp_in;
   logic [15:0]   dp_ff, dp_in;
   logic [30:0]   key_ff, key_in;
   logic [CW-1:0] tries_ff, tries_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [8:0]    rsp_slot_ff, rsp_slot_in;

   logic          req_xfer;
   logic          out_busy;
   logic          emit_fire;

   assign req_stall = (cw.op != OP_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign emit_fire = (cw.op == OP_EMIT) && !out_busy;

   // ---------------------------------------------------------------------
   // Shared remainder unit
   // ---------------------------------------------------------------------
   logic        mod_start;
   logic [30:0] mod_dividend;
   logic [4:0]  mod_nbits;
   logic [15:0] mod_divisor;
   logic        mod_busy;
   logic [15:0] mod_rem;

   always_comb begin
      mod_start    = 1'b0;
      mod_dividend = {key_ff};
      mod_nbits    = MOD_LEN_KEY;
      mod_divisor  = 16'(tm);
      unique case (cw.op)
         OP_MOD_TPOS: begin
            mod_start    = 1'b1;
            mod_dividend = {16'(tp_ff), 15'd0};
            mod_nbits    = MOD_LEN_SHORT;
         end
         OP_MOD_DPOS: begin
            mod_start    = 1'b1;
            mod_dividend = {dp_ff, 15'd0};
            mod_nbits    = MOD_LEN_SHORT;
            mod_divisor  = dm;
         end
         OP_MOD_KEY_T: begin
            mod_start    = 1'b1;
         end
         OP_MOD_KEY_D: begin
            mod_start    = 1'b1;
            mod_divisor  = dm;
         end
         OP_MOD_JUMP: begin
            // jump distance is the second dial plus one, taken mod table size
            mod_start    = 1'b1;
            mod_dividend = {16'(dp_ff + 16'd1), 15'd0};
            mod_nbits    = MOD_LEN_SHORT;
         end
         default: ;
      endcase
   end

   ddhs_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (mod_dividend),
      .nbits    (mod_nbits),
      .divisor  (mod_divisor),
      .busy     (mod_busy),
      .rem      (mod_rem)
   );

   // ---------------------------------------------------------------------
   // Occupancy RAM: cleared after reset, read at tp, set on emit
   // ---------------------------------------------------------------------
   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [0:0]    ram_wdata;
   logic [0:0]    ram_rdata;

   assign ram_we    = (cw.op == OP_CLEAR) || emit_fire;
   assign ram_addr  = (cw.op == OP_CLEAR) ? clr_ff : tp_ff;
   assign ram_wdata = (cw.op == OP_CLEAR) ? 1'b0 : 1'b1;

   ddhs_ram #(
      .WIDTH (1),
      .DEPTH (TABLE_DEPTH)
   ) u_occ_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // ---------------------------------------------------------------------
   // Dial arithmetic; all operands already below their modulus
   // ---------------------------------------------------------------------
   logic [TMW:0] tp_x, tm_x, rem_t, tp_sum, tp_inc;
   logic [16:0]  dp_x, dm_x, rem_d, dp_jump, dp_sum;

   assign tp_x    = (TMW + 1)'(tp_ff);
   assign tm_x    = (TMW + 1)'(tm);
   assign rem_t   = (TMW + 1)'(mod_rem);
   assign tp_sum  = tp_x + rem_t;
   assign tp_inc  = tp_x + (TMW + 1)'(1);
   assign dp_x    = {1'b0, dp_ff};
   assign dm_x    = {1'b0, dm};
   assign rem_d   = {1'b0, mod_rem};
   assign dp_jump = dp_x + 17'd1;
   assign dp_sum  = dp_x + dp_jump;

   always_comb begin
      tp_in    = tp_ff;
      dp_in    = dp_ff;
      tries_in = tries_ff;
      clr_in   = clr_ff;
      key_in   = req_xfer ? req_key : key_ff;
      unique case (cw.op)
         OP_CLEAR: clr_in = AW'(clr_ff + AW'(1));
         OP_LD_TP: tp_in = AW'(mod_rem);
         OP_LD_DP: dp_in = mod_rem;
         OP_FWD_KEY: begin
            tp_in = (tp_sum >= tm_x) ? AW'(tp_sum - tm_x) : AW'(tp_sum);
         end
         OP_BACK_KEY: begin
            dp_in = (dp_x >= rem_d) ? 16'(dp_x - rem_d) : 16'(dp_x + dm_x - rem_d);
         end
         OP_JUMP: begin
            tp_in = (tp_x >= rem_t) ? AW'(tp_x - rem_t) : AW'(tp_x + tm_x - rem_t);
            priority if (dp_jump == dm_x) begin
               dp_in = dp_ff;
            end else if (dp_sum >= dm_x) begin
               dp_in = 16'(dp_sum - dm_x);
            end else begin
               dp_in = 16'(dp_sum);
            end
            tries_in = CW'(2);
         end
         OP_STEP: begin
            tp_in    = (tp_inc == tm_x) ? '0 : AW'(tp_inc);
            dp_in    = (dp_ff == '0) ? 16'(dm_x - 17'd1) : 16'(dp_x - 17'd1);
            tries_in = CW'(tries_ff + CW'(1));
         end
         default: ;
      endcase
   end

   // result register: next key may start while a slot waits here
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_slot_in  = rsp_slot_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
         rsp_slot_in  = 9'({1'b0, tp_ff} + (AW + 1)'(1));
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tp_ff        <= '0;
         dp_ff        <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tp_ff        <= tp_in;
         dp_ff        <= dp_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff      <= key_in;
      tries_ff    <= tries_in;
      rsp_slot_ff <= rsp_slot_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_slot  = rsp_slot_ff;

   // ---------------------------------------------------------------------
   // Sequencer flags
   // ---------------------------------------------------------------------
   assign flags.clr_more  = (clr_ff != AW'(TABLE_DEPTH - 1));
   assign flags.no_req    = !req_valid;
   assign flags.mod_busy  = mod_busy;
   assign flags.free      = (ram_rdata == 1'b0);
   assign flags.exhausted = (tries_ff > CW'(tm));
   assign flags.out_busy  = out_busy;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   // a slot is only ever claimed where the probe found it empty
   `DDHS_ASSERT_NOW(a_claim_free, clock, reset, emit_fire, ram_rdata == 1'b0)
   // linear probing only continues while tries remain
   `DDHS_ASSERT_NOW(a_step_in_budget, clock, reset, cw.op == OP_STEP, tries_ff <= CW'(tm))
   // a claimed slot shows up as a one-based number
   `DDHS_ASSERT_NEXT(a_emit_slot, clock, reset, emit_fire, rsp_valid && rsp_slot != 9'd0)
   // every remainder run reports busy in the cycle after it is started
   `DDHS_ASSERT_NEXT(a_mod_runs, clock, reset, mod_start, mod_busy)

endmodule
